// ===== hw/rtl/hps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants of the Hammersley point generator.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int NS_W       = 21;
    localparam int RADIX_W    = 5;
    localparam int SAMPLE_W   = 21;
    localparam int COORD_W    = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 88;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [NS_W-1:0]    NS_RESET    = 21'd1;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd2;

    // register select, taken from the word address bit
    localparam logic REG_NUM_SAMPLES = 1'b0;
    localparam logic REG_RADIX       = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_HORNER,
        ST_FINISH
    } hps_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== hw/rtl/hammersley_point_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hammersley_point_generator
// Streams successive 2D Hammersley points in 32-bit fixed point.
// ----------------------------------------------------------------------------
// Each input item (restart flag) yields one output item: x = i/N, y = radical
// inverse of i in the configured radix, sample number i+1 and a wrap flag.
// N and the radix are set over the APB port; writing N clears the index.
// Flow: the index is shifted MSB first into a row of base-b digit cells
// while the x division runs alongside, then the m digits of i are folded
// into the reversed value and b^m, then a bit-serial divider forms y.
// One item is in work at a time. The result sits in an output register,
// so a new item is taken while it waits; if the receiver stalls, the next
// finished result waits in the core. Reset clears the index to 0, N to 1
// and the radix to 2.
// ----------------------------------------------------------------------------
module hammersley_point_generator #(
    parameter int INDEX_BITS    = 20,
    parameter int FRACTION_BITS = 32,
    parameter int MAX_RADIX     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hps_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // restart
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [hps_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // x_fraction, y_fraction, sample_number
    output logic                              m_axis_tuser,   // wrapped
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hps_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hps_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hps_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import hps_pkg::*;

    localparam int NDIG  = INDEX_BITS;
    localparam int DW    = $clog2(MAX_RADIX);
    localparam int BW    = $clog2(MAX_RADIX + 1);
    localparam int TW    = DW + 1;
    localparam int RW    = INDEX_BITS + DW;
    localparam int NW    = INDEX_BITS + 1;
    localparam int LW    = (NS_W > NW) ? NS_W : NW;
    localparam int RCW   = (RADIX_W > BW) ? RADIX_W : BW;
    localparam int CNT_W = $clog2(2 * INDEX_BITS - 1);
    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(2 * INDEX_BITS - 2);
    localparam logic [CNT_W-1:0] FEED_END  = CNT_W'(INDEX_BITS);

    // configuration
    logic [NS_W-1:0]    num_samples_reg;
    logic [RADIX_W-1:0] radix_reg;
    logic               cfg_wr;

    // control
    hps_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] index_reg;
    logic               out_valid_reg, out_valid_next;
    logic               accept;
    logic               out_load;
    logic               ydiv_start;
    logic               feed_v;

    // digit cells
    logic [NDIG-1:0][DW-1:0] digit_reg, digit_next;
    logic [NDIG-1:0]         cv_reg, cv_next;
    logic [NDIG-1:0]         cc_reg, cc_next;
    logic [NDIG-1:0]         cell_in_v;
    logic [NDIG-1:0]         cell_in_c;
    logic [NDIG-1:0][TW-1:0] cell_sum;
    logic [NDIG-1:0][TW-1:0] cell_dif;
    logic [NDIG-1:0]         cell_ge;
    logic [NDIG-1:0][DW-1:0] cell_digit;

    // payload
    logic [INDEX_BITS-1:0] src_reg, src_next;
    logic [RW-1:0]         rev_reg, rev_next;
    logic [RW-1:0]         scale_reg, scale_next;
    logic [RW+BW-1:0]      rev_prod;
    logic [RW+BW-1:0]      scale_prod;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic                  wrap_reg;
    logic [COORD_W-1:0]    x_out_reg, y_out_reg;
    logic [SAMPLE_W-1:0]   sn_out_reg;
    logic                  wrap_out_reg;

    // effective operands
    logic [LW-1:0]  ns_ext, limit_ext, n_ext;
    logic [NW-1:0]  n_eff;
    logic [RCW-1:0] rad_ext, b_ext;
    logic [BW-1:0]  b_eff;
    logic [LW-1:0]  idx_ext, i_ext, i_inc;
    logic           wrap_now;

    div_status_t        xdiv_st, ydiv_st;
    logic [COORD_W-1:0] xq, yq;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_samples_reg <= NS_RESET;
            radix_reg       <= RADIX_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[APB_ADDR_W-1])
                REG_NUM_SAMPLES: num_samples_reg <= pwdata[NS_W-1:0];
                REG_RADIX:       radix_reg       <= pwdata[RADIX_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[APB_ADDR_W-1])
            REG_NUM_SAMPLES: prdata = APB_DATA_W'(num_samples_reg);
            REG_RADIX:       prdata = APB_DATA_W'(radix_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- effective N, radix and index ----------------
    always_comb
    begin
        ns_ext    = LW'(num_samples_reg);
        limit_ext = LW'(1) << INDEX_BITS;
        if (ns_ext == '0)
            n_ext = LW'(1);
        else if (ns_ext > limit_ext)
            n_ext = limit_ext;
        else
            n_ext = ns_ext;
        n_eff = n_ext[NW-1:0];

        rad_ext = RCW'(radix_reg);
        if (rad_ext < RCW'(2))
            b_ext = RCW'(2);
        else if (rad_ext > RCW'(MAX_RADIX))
            b_ext = RCW'(MAX_RADIX);
        else
            b_ext = rad_ext;
        b_eff = b_ext[BW-1:0];

        idx_ext  = s_axis_tdata[0] ? '0 : LW'(index_reg);
        wrap_now = idx_ext >= LW'(n_eff);
        i_ext    = wrap_now ? '0 : idx_ext;
        i_inc    = i_ext + LW'(1);
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            index_reg <= '0;
        else if (cfg_wr && paddr[APB_ADDR_W-1] == REG_NUM_SAMPLES)
            index_reg <= '0;
        else if (accept)
            index_reg <= i_inc[SAMPLE_W-1:0];
    end

    // ---------------- digit cells ----------------
    assign feed_v    = (state_reg == ST_CONV) && (cnt_reg < FEED_END);
    assign cell_in_v = {cv_reg[NDIG-2:0], feed_v};
    assign cell_in_c = {cc_reg[NDIG-2:0], src_reg[INDEX_BITS-1]};

    always_comb
    begin
        for (int k = 0; k < NDIG; k++)
        begin
            cell_sum[k]   = {digit_reg[k], cell_in_c[k]};
            cell_dif[k]   = cell_sum[k] - TW'(b_eff);
            cell_ge[k]    = cell_sum[k] >= TW'(b_eff);
            cell_digit[k] = cell_ge[k] ? cell_dif[k][DW-1:0] : cell_sum[k][DW-1:0];
        end
    end

    assign rev_prod   = rev_reg * b_eff;
    assign scale_prod = scale_reg * b_eff;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        src_next   = src_reg;
        digit_next = digit_reg;
        cv_next    = '0;
        cc_next    = cc_reg;
        rev_next   = rev_reg;
        scale_next = scale_reg;
        ydiv_start = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CONV;
                    cnt_next   = '0;
                    src_next   = i_ext[INDEX_BITS-1:0];
                    digit_next = '0;
                    rev_next   = '0;
                    scale_next = RW'(1);
                end
            end
            ST_CONV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (feed_v)
                    src_next = src_reg << 1;
                for (int k = 0; k < NDIG; k++)
                begin
                    if (cell_in_v[k])
                        digit_next[k] = cell_digit[k];
                end
                cc_next = cell_in_v & cell_ge;
                if (cnt_reg == CONV_LAST)
                    state_next = ST_HORNER;
                else
                    cv_next = cell_in_v;
            end
            ST_HORNER:
            begin
                if (digit_reg == '0)
                begin
                    ydiv_start = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    // least significant digit first
                    rev_next   = rev_prod[RW-1:0] + RW'(digit_reg[0]);
                    scale_next = scale_prod[RW-1:0];
                    digit_next = digit_reg >> DW;
                end
            end
            ST_FINISH:
            begin
                if (xdiv_st.done && ydiv_st.done && (!out_valid_reg || m_axis_tready))
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cv_reg        <= cv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        digit_reg <= digit_next;
        cc_reg    <= cc_next;
        rev_reg   <= rev_next;
        scale_reg <= scale_next;
        if (accept)
        begin
            sample_reg <= i_inc[SAMPLE_W-1:0];
            wrap_reg   <= wrap_now;
        end
        if (out_load)
        begin
            x_out_reg    <= xq;
            y_out_reg    <= yq;
            sn_out_reg   <= sample_reg;
            wrap_out_reg <= wrap_reg;
        end
    end

    // ---------------- dividers ----------------
    hps_frac_div #(
        .DEN_W     (NW),
        .FRAC_BITS (FRACTION_BITS)
    ) u_xdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .num      (i_ext[NW-1:0]),
        .den      (n_eff),
        .status   (xdiv_st),
        .quotient (xq)
    );

    hps_frac_div #(
        .DEN_W     (RW),
        .FRAC_BITS (FRACTION_BITS)
    ) u_ydiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ydiv_start),
        .num      (rev_reg),
        .den      (scale_reg),
        .status   (ydiv_st),
        .quotient (yq)
    );

    // ---------------- output ----------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({sn_out_reg, y_out_reg, x_out_reg});
    assign m_axis_tuser  = wrap_out_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CONV) && (cnt_reg == '0))
        else $error("item accepted but conversion did not start");

    a_cells_idle_in_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HORNER) |-> (cv_reg == '0))
        else $error("digit cell still active during digit fold");

    a_load_after_divs: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (xdiv_st.done && ydiv_st.done && !xdiv_st.busy && !ydiv_st.busy))
        else $error("result loaded before both divisions finished");

    a_wrap_restarts_index: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && wrap_now) |=> (index_reg == SAMPLE_W'(1)))
        else $error("index not restarted after wrap");
`endif

endmodule

// ===== hw/rtl/hps_frac_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_frac_div
// Bit-serial restoring divider: floor(num * 2^FRAC_BITS / den), num < den.
// ----------------------------------------------------------------------------
module hps_frac_div #(
    parameter int DEN_W     = 21,
    parameter int FRAC_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DEN_W-1:0]             num,
    input  logic [DEN_W-1:0]             den,
    output hps_pkg::div_status_t         status,
    output logic [hps_pkg::COORD_W-1:0]  quotient
);
    import hps_pkg::*;

    localparam int QW    = (FRAC_BITS > COORD_W) ? FRAC_BITS : COORD_W;
    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(FRAC_BITS - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [QW-1:0]    q_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_dif;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [QW-1:0]    q_next;

    always_comb
    begin
        rem_sh   = {rem_reg, 1'b0};
        rem_dif  = rem_sh - {1'b0, den_reg};
        fits     = rem_sh >= {1'b0, den_reg};
        rem_next = fits ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        q_next   = {q_reg[QW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = q_reg[COORD_W-1:0];

endmodule

// ===== tb/hps_point_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_point_checker
// Predicts and checks every point of the Hammersley point generator.
// ----------------------------------------------------------------------------
// Follows register writes on the APB port and items accepted on the input
// stream. It keeps its own copy of N, the radix and the point index, and
// queues one expected point per input item. Each output item is compared,
// field by field, against the oldest queued point.
// ----------------------------------------------------------------------------
module hps_point_checker #(
    parameter int INDEX_BITS    = 20,
    parameter int FRACTION_BITS = 32,
    parameter int MAX_RADIX     = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [hps_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // restart
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [hps_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // x_fraction, y_fraction, sample_number
    input  logic                               m_axis_tuser,   // wrapped
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hps_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic                               pready,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 points_checked,
    output int                                 wraps_seen
);

    localparam int X_LO   = 0;
    localparam int Y_LO   = hps_pkg::COORD_W;
    localparam int SN_LO  = 2 * hps_pkg::COORD_W;
    localparam int PAD_LO = SN_LO + hps_pkg::SAMPLE_W;
    localparam longint unsigned INDEX_LIMIT = 64'd1 << INDEX_BITS;

    typedef struct packed {
        logic [hps_pkg::COORD_W-1:0]  x_fraction;
        logic [hps_pkg::COORD_W-1:0]  y_fraction;
        logic [hps_pkg::SAMPLE_W-1:0] sample_number;
        logic                         wrapped;
    } point_t;

    logic [hps_pkg::NS_W-1:0]    num_samples_reg;
    logic [hps_pkg::RADIX_W-1:0] radix_reg;
    logic [hps_pkg::NS_W-1:0]    next_index;
    point_t                      expected_points[$];
    int                          fails   = 0;
    int                          checked = 0;
    int                          wraps   = 0;

    // floor(num * 2^F / den), num < den
    function automatic logic [hps_pkg::COORD_W-1:0] scaled_fraction(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned quotient;
        quotient = (num << FRACTION_BITS) / den;
        return quotient[hps_pkg::COORD_W-1:0];
    endfunction

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_t          want;
        longint unsigned count_eff;
        longint unsigned base;
        longint unsigned idx;
        longint unsigned digits;
        longint unsigned reversed;
        longint unsigned scale;
        logic            wrap;
        if (!rst_n)
        begin
            num_samples_reg = hps_pkg::NS_RESET;
            radix_reg       = hps_pkg::RADIX_RESET;
            next_index      = '0;
            expected_points.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == hps_pkg::REG_NUM_SAMPLES)
                begin
                    num_samples_reg = pwdata[hps_pkg::NS_W-1:0];
                    next_index      = '0;
                end
                else
                    radix_reg = pwdata[hps_pkg::RADIX_W-1:0];
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("output item with no point pending: tdata %0h tuser %0b",
                           m_axis_tdata, m_axis_tuser);
                    fails++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    check_field("x_fraction", want.x_fraction,
                                m_axis_tdata[Y_LO-1:X_LO]);
                    check_field("y_fraction", want.y_fraction,
                                m_axis_tdata[SN_LO-1:Y_LO]);
                    check_field("sample_number", want.sample_number,
                                m_axis_tdata[PAD_LO-1:SN_LO]);
                    check_field("wrapped", want.wrapped, m_axis_tuser);
                    check_field("tdata padding", 0,
                                m_axis_tdata[hps_pkg::OUT_DATA_W-1:PAD_LO]);
                    checked++;
                    if (want.wrapped)
                        wraps++;
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (num_samples_reg == 0)
                    count_eff = 1;
                else if (num_samples_reg > INDEX_LIMIT)
                    count_eff = INDEX_LIMIT;
                else
                    count_eff = num_samples_reg;

                if (radix_reg < 2)
                    base = 2;
                else if (radix_reg > MAX_RADIX)
                    base = MAX_RADIX;
                else
                    base = radix_reg;

                if (s_axis_tdata[0])
                    next_index = '0;
                idx  = next_index;
                wrap = 1'b0;
                if (idx >= count_eff)
                begin
                    idx  = 0;
                    wrap = 1'b1;
                end

                // digits of idx in reverse order, and b^m
                digits   = idx;
                reversed = 0;
                scale    = 1;
                while (digits != 0)
                begin
                    reversed = reversed * base + digits % base;
                    scale    = scale * base;
                    digits   = digits / base;
                end

                want.x_fraction    = scaled_fraction(idx, count_eff);
                want.y_fraction    = (reversed == 0) ? '0 : scaled_fraction(reversed, scale);
                want.sample_number = idx[hps_pkg::SAMPLE_W-1:0] + 1'b1;
                want.wrapped       = wrap;
                expected_points.insert(expected_points.size(), want);
                next_index = idx[hps_pkg::NS_W-1:0] + 1'b1;
            end
        end
        fail_count     <= fails;
        pending        <= expected_points.size();
        points_checked <= checked;
        wraps_seen     <= wraps;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream and register test of the Hammersley point generator.
// ----------------------------------------------------------------------------
// Resets the block, runs a short directed set of points over the edge
// settings of N and the radix, then random phases of points with random
// restarts under fresh register settings. Both stream sides idle at random,
// one phase runs with no idling and one holds the receiver off long enough
// to back the block up. Checking is done by hps_point_checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int INDEX_BITS     = 20;
    localparam int FRACTION_BITS  = 32;
    localparam int MAX_RADIX      = 16;
    localparam int TOTAL_ITEMS    = 850;
    localparam int IDLE_PCT       = 12;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int STEADY_PHASE   = 4;
    localparam int HOLD_PHASE     = 7;

    logic                               clk           = 1'b0;
    logic                               rst_n         = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [hps_pkg::IN_DATA_W-1:0]      s_axis_tdata  = '0;   // restart
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [hps_pkg::OUT_DATA_W-1:0]     m_axis_tdata;         // x_fraction, y_fraction, sample_number
    logic                               m_axis_tuser;         // wrapped
    logic                               psel          = 1'b0;
    logic                               penable       = 1'b0;
    logic                               pwrite        = 1'b0;
    logic [hps_pkg::APB_ADDR_W-1:0]     paddr         = '0;
    logic [hps_pkg::APB_DATA_W-1:0]     pwdata        = '0;
    logic [hps_pkg::APB_DATA_W-1:0]     prdata;
    logic                               pready;

    int   fail_count;
    int   pending;
    int   points_checked;
    int   wraps_seen;

    logic steady      = 1'b0;
    logic hold_req    = 1'b0;
    logic hold_used   = 1'b0;
    int   hold_left   = 0;
    int   quiet_cycles = 0;
    int   points_sent  = 0;
    int   restarts_sent = 0;
    int   settings_used = 0;

    hammersley_point_generator #(
        .INDEX_BITS    (INDEX_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .MAX_RADIX     (MAX_RADIX)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    hps_point_checker #(
        .INDEX_BITS    (INDEX_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .MAX_RADIX     (MAX_RADIX)
    ) point_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .pending        (pending),
        .points_checked (points_checked),
        .wraps_seen     (wraps_seen)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver: random stalls, one long hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_req && !hold_used)
        begin
            m_axis_tready <= 1'b0;
            hold_used     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
        end
        else
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $error("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic sel, input logic [hps_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_points;
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic reconfigure(input logic write_ns, input logic [31:0] ns_word,
                               input logic write_radix, input logic [31:0] radix_word);
        drain_points();
        if (write_ns)
            write_reg(hps_pkg::REG_NUM_SAMPLES, ns_word);
        if (write_radix)
            write_reg(hps_pkg::REG_RADIX, radix_word);
        settings_used++;
    endtask

    task automatic send_points(input int count, input int restart_pct);
        logic restart;
        for (int k = 0; k < count; k++)
        begin
            if (!steady && $urandom_range(99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge clk);
            end
            restart = ($urandom_range(99) < restart_pct);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {{(hps_pkg::IN_DATA_W-1){1'b0}}, restart};
            do
                @(posedge clk);
            while (!s_axis_tready);
            points_sent++;
            if (restart)
                restarts_sent++;
        end
    endtask

    initial
    begin
        int                       phase;
        int                       which;
        logic [31:0]              ns_field;
        logic [31:0]              ns_word;
        logic [31:0]              radix_word;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: N = 1 wraps on every point after the first but a restart
        send_points(3, 0);
        send_points(1, 100);
        // N of zero and radix below two, both hidden under junk upper bits
        reconfigure(1'b1, 32'hFFE0_0000, 1'b1, 32'hFFFF_FFE1);
        send_points(2, 0);
        // oversized N, radix above the maximum
        reconfigure(1'b1, 32'h001F_FFFF, 1'b1, 32'h0000_001F);
        send_points(3, 0);
        reconfigure(1'b1, 32'h0010_0000, 1'b1, 32'h0000_0011);
        send_points(2, 0);
        send_points(1, 100);
        reconfigure(1'b1, 32'd5, 1'b1, 32'd3);
        send_points(7, 0);
        send_points(2, 100);
        // radix write alone keeps the index
        reconfigure(1'b0, '0, 1'b1, 32'd16);
        send_points(3, 0);

        phase = 0;
        while (points_sent < TOTAL_ITEMS)
        begin
            phase++;
            case ($urandom_range(9))
                0:       ns_field = '0;
                1:       ns_field = $urandom_range(32'h001F_FFFF, 32'h0010_0001);
                2:       ns_field = 32'h0010_0000;
                3:       ns_field = $urandom_range(32'h000F_FFFF, 1);
                default: ns_field = $urandom_range(40, 1);
            endcase
            ns_word    = ($urandom() & 32'hFFE0_0000) | ns_field;
            radix_word = ($urandom() & 32'hFFFF_FFE0) |
                         (($urandom_range(99) < 80) ? $urandom_range(MAX_RADIX, 2)
                                                    : $urandom_range(31, 0));
            which = $urandom_range(3);
            steady <= (phase == STEADY_PHASE);
            reconfigure(which != 1, ns_word, which != 0, radix_word);
            if (phase == HOLD_PHASE)
            begin
                hold_req <= 1'b1;
                send_points(160, 8);
            end
            else if (phase == STEADY_PHASE)
                send_points(150, 8);
            else
                send_points($urandom_range(50, 15), 8);
        end

        drain_points();
        repeat (100) @(posedge clk);

        $display("Checked %0d points over %0d register settings: %0d wraps, %0d restarts,",
                 points_checked, settings_used, wraps_seen, restarts_sent);
        $display("random idling on both streams and one %0d-cycle receiver hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
